[src/irpd_pkg.sv]
// ----------------------------------------------------------------------------
// irpd_pkg
// Types and constants shared by the IR pulse-distance frame decoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

  localparam int unsigned FrameBytes = 8;
  localparam int unsigned BlockBytes = 4;
  localparam int unsigned BlockBits  = BlockBytes * 8;
  localparam int unsigned FrameBits  = FrameBytes * 8;
  localparam int unsigned BitCntW    = $clog2(BlockBits);

  localparam int unsigned DurW  = 16;
  localparam int unsigned TolW  = 7;
  localparam int unsigned ProdW = 24;
  localparam int unsigned NumDur = 6;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [3:0] CkStart     = 4'd10;
  localparam logic [2:0] FooterValue = 3'b010;
  localparam logic [1:0] FooterLast  = 2'd2;
  localparam logic [TolW-1:0] Hundred = 7'd100;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_HEADER_MARK   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEADER_SPACE  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BIT_MARK      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ONE_SPACE     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ZERO_SPACE    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_MSG_SPACE     = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_TOLERANCE     = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_ENFORCE_CKSUM = 3'd7;

  localparam logic [DurW-1:0] RST_HEADER_MARK  = 16'd9000;
  localparam logic [DurW-1:0] RST_HEADER_SPACE = 16'd4500;
  localparam logic [DurW-1:0] RST_BIT_MARK     = 16'd620;
  localparam logic [DurW-1:0] RST_ONE_SPACE    = 16'd1600;
  localparam logic [DurW-1:0] RST_ZERO_SPACE   = 16'd540;
  localparam logic [DurW-1:0] RST_MSG_SPACE    = 16'd19000;
  localparam logic [TolW-1:0] RST_TOLERANCE    = 7'd25;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_HEADER   = 3'd1,
    ST_BLOCK1   = 3'd2,
    ST_FOOTER   = 3'd3,
    ST_MSGSPACE = 3'd4,
    ST_BLOCK2   = 3'd5,
    ST_CHECKSUM = 3'd6
  } status_e;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_BLOCK1   = 5'b00010,
    PH_FOOTER   = 5'b00100,
    PH_MSGSPACE = 5'b01000,
    PH_BLOCK2   = 5'b10000
  } phase_e;

  typedef struct packed {
    logic            start_of_capture;
    logic [DurW-1:0] mark_us;
    logic [DurW-1:0] space_us;
  } in_t;

  typedef struct packed {
    logic [FrameBits-1:0] frame_bits;
    logic [2:0]           status;
    logic                 checksum_mismatch;
  } out_t;

endpackage

[src/ir_pulse_distance_frame_decoder_unit.sv]
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_decoder_unit
// Decodes measured mark/space pairs into an 8-byte frame with nibble checksum.
// ----------------------------------------------------------------------------
// The result is in the output register in the cycle after the pair that
// completes or fails the frame is transferred.
// Throughput: one pair per cycle while no result waits on the output; the
// tolerance bound products are registered, so the input also stalls after
// reset and after each configuration write. Reset restores the default
// durations and goes idle.
module ir_pulse_distance_frame_decoder_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [irpd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [irpd_pkg::DurW-1:0]        cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  irpd_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output irpd_pkg::out_t                   out_data_o
);
  import irpd_pkg::*;

  localparam int unsigned DurIdxW = $clog2(NumDur);

  logic [DurW-1:0]  dur_q [NumDur];
  logic [TolW-1:0]  tol_q;
  logic             enforce_q;
  logic             busy_q;
  logic [ProdW-1:0] lo_q [NumDur];
  logic [ProdW-1:0] hi_q [NumDur];

  phase_e               phase_q, phase_d;
  logic [BitCntW-1:0]   bc_q, bc_d;
  logic [FrameBits-1:0] frame_q, frame_d;
  logic [2:0]           footer_q, footer_d;

  logic out_valid_q;
  out_t out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q[CFG_HEADER_MARK]  <= RST_HEADER_MARK;
      dur_q[CFG_HEADER_SPACE] <= RST_HEADER_SPACE;
      dur_q[CFG_BIT_MARK]     <= RST_BIT_MARK;
      dur_q[CFG_ONE_SPACE]    <= RST_ONE_SPACE;
      dur_q[CFG_ZERO_SPACE]   <= RST_ZERO_SPACE;
      dur_q[CFG_MSG_SPACE]    <= RST_MSG_SPACE;
      tol_q     <= RST_TOLERANCE;
      enforce_q <= 1'b1;
      busy_q    <= 1'b1;
    end else begin
      busy_q <= cfg_we_i;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TOLERANCE:     tol_q <= cfg_wdata_i[TolW-1:0];
          CFG_ENFORCE_CKSUM: enforce_q <= cfg_wdata_i[0];
          default:           dur_q[cfg_idx_i[DurIdxW-1:0]] <= cfg_wdata_i;
        endcase
      end
    end
  end

  // bound products: (100 -/+ T) * E, compared against 100 * measured
  logic [TolW:0] tol_lo, tol_hi;
  always_comb begin
    tol_lo = (tol_q >= Hundred) ? '0 : {1'b0, Hundred - tol_q};
    tol_hi = {1'b0, Hundred} + {1'b0, tol_q};
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumDur; i++) begin
      lo_q[i] <= ProdW'(tol_lo * dur_q[i]);
      hi_q[i] <= ProdW'(tol_hi * dur_q[i]);
    end
  end

  // m >= floor(lo/100) <=> lo <= 100m+99 ; m <= floor(hi/100) <=> 100m <= hi
  logic [ProdW-1:0] m100, s100;
  always_comb begin
    m100 = (ProdW'(in_data_i.mark_us) << 6) + (ProdW'(in_data_i.mark_us) << 5)
         + (ProdW'(in_data_i.mark_us) << 2);
    s100 = (ProdW'(in_data_i.space_us) << 6) + (ProdW'(in_data_i.space_us) << 5)
         + (ProdW'(in_data_i.space_us) << 2);
  end

  function automatic logic in_range(logic [ProdW-1:0] v100, logic [ProdW-1:0] lo,
                                    logic [ProdW-1:0] hi);
    return (lo <= v100 + ProdW'(99)) && (v100 <= hi);
  endfunction

  logic hdr_ok, one_ok, zero_ok, msg_ok, bit_ok, bit_val, mark_ok;
  always_comb begin
    mark_ok = in_range(m100, lo_q[CFG_BIT_MARK], hi_q[CFG_BIT_MARK]);
    hdr_ok  = in_range(m100, lo_q[CFG_HEADER_MARK], hi_q[CFG_HEADER_MARK])
            && in_range(s100, lo_q[CFG_HEADER_SPACE], hi_q[CFG_HEADER_SPACE]);
    one_ok  = mark_ok && in_range(s100, lo_q[CFG_ONE_SPACE], hi_q[CFG_ONE_SPACE]);
    zero_ok = mark_ok && in_range(s100, lo_q[CFG_ZERO_SPACE], hi_q[CFG_ZERO_SPACE]);
    msg_ok  = mark_ok && in_range(s100, lo_q[CFG_MSG_SPACE], hi_q[CFG_MSG_SPACE]);
    bit_ok  = one_ok || zero_ok;
    bit_val = one_ok;
  end

  logic in_xfer;
  assign in_ready_o = !busy_q && (!out_valid_q || out_ready_i);
  assign in_xfer    = in_valid_i && in_ready_o;

  logic [FrameBits-1:0] frame_set;
  logic [3:0]           sum;
  logic                 mis;
  logic                 emit;
  out_t                 res;

  always_comb begin
    phase_d   = phase_q;
    bc_d      = bc_q;
    frame_d   = frame_q;
    footer_d  = footer_q;
    emit      = 1'b0;
    res       = '0;
    frame_set = FrameBits'(bit_val) << {phase_q == PH_BLOCK2, bc_q};
    sum = '0;
    mis = 1'b0;
    if (in_data_i.start_of_capture) begin
      frame_d  = '0;
      bc_d     = '0;
      footer_d = '0;
      if (hdr_ok) begin
        phase_d = PH_BLOCK1;
      end else begin
        emit   = 1'b1;
        res.status = ST_HEADER;
        phase_d = PH_IDLE;
      end
      res.frame_bits = '0;
    end else begin
      case (phase_q)
        PH_BLOCK1, PH_BLOCK2: begin
          if (!bit_ok) begin
            emit = 1'b1;
            res.frame_bits = frame_q;
            res.status = (phase_q == PH_BLOCK1) ? ST_BLOCK1 : ST_BLOCK2;
            phase_d = PH_IDLE;
          end else begin
            frame_d = frame_q | frame_set;
            bc_d    = bc_q + 1'b1;
            if (&bc_q) begin
              if (phase_q == PH_BLOCK1) begin
                phase_d  = PH_FOOTER;
                footer_d = '0;
              end else begin
                sum = CkStart + frame_d[3:0] + frame_d[11:8] + frame_d[19:16]
                    + frame_d[27:24] + frame_d[39:36] + frame_d[47:44] + frame_d[55:52];
                mis = (sum != frame_d[63:60]);
                emit = 1'b1;
                res.frame_bits = frame_d;
                res.status = (mis && enforce_q) ? ST_CHECKSUM : ST_OK;
                res.checksum_mismatch = mis;
                phase_d = PH_IDLE;
              end
            end
          end
        end
        PH_FOOTER: begin
          if (!bit_ok) begin
            emit = 1'b1;
            res.frame_bits = frame_q;
            res.status = ST_FOOTER;
            phase_d = PH_IDLE;
          end else begin
            footer_d = footer_q | (3'(bit_val) << bc_q[1:0]);
            bc_d     = bc_q + 1'b1;
            if (bc_q[1:0] == FooterLast) begin
              bc_d = '0;
              if (footer_d != FooterValue) begin
                emit = 1'b1;
                res.frame_bits = frame_q;
                res.status = ST_FOOTER;
                phase_d = PH_IDLE;
              end else begin
                phase_d = PH_MSGSPACE;
              end
            end
          end
        end
        PH_MSGSPACE: begin
          if (!msg_ok) begin
            emit = 1'b1;
            res.frame_bits = frame_q;
            res.status = ST_MSGSPACE;
            phase_d = PH_IDLE;
          end else begin
            phase_d = PH_BLOCK2;
            bc_d    = '0;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bc_q        <= '0;
      frame_q     <= '0;
      footer_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase_q  <= phase_d;
        bc_q     <= bc_d;
        frame_q  <= frame_d;
        footer_q <= footer_d;
      end
      if (in_xfer && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
